@@ sv/tcie_pkg.sv @@
// Shared opcodes, field widths and the result record for the instruction executor.
// No dependencies.
package tcie_pkg;
    localparam int CMD_W = 5;
    localparam int FA_W  = 10;
    localparam int FB_W  = 16;
    localparam int PC_W  = 11;
    localparam int WORD_W = 32;

    localparam logic [CMD_W-1:0] OP_ADD  = 5'd0;
    localparam logic [CMD_W-1:0] OP_SUB  = 5'd1;
    localparam logic [CMD_W-1:0] OP_MUL  = 5'd2;
    localparam logic [CMD_W-1:0] OP_DIV  = 5'd3;
    localparam logic [CMD_W-1:0] OP_ST   = 5'd4;
    localparam logic [CMD_W-1:0] OP_LD   = 5'd5;
    localparam logic [CMD_W-1:0] OP_IMM  = 5'd6;
    localparam logic [CMD_W-1:0] OP_EQU  = 5'd7;
    localparam logic [CMD_W-1:0] OP_LT   = 5'd8;
    localparam logic [CMD_W-1:0] OP_LE   = 5'd9;
    localparam logic [CMD_W-1:0] OP_GT   = 5'd10;
    localparam logic [CMD_W-1:0] OP_GE   = 5'd11;
    localparam logic [CMD_W-1:0] OP_JMPC = 5'd12;
    localparam logic [CMD_W-1:0] OP_CALL = 5'd13;
    localparam logic [CMD_W-1:0] OP_RET  = 5'd14;
    localparam logic [CMD_W-1:0] OP_PRT  = 5'd15;
    localparam logic [CMD_W-1:0] OP_JMP  = 5'd16;

    typedef struct packed {
        logic [PC_W-1:0]   next_pc;
        logic              halted;
        logic              print_valid;
        logic [WORD_W-1:0] print_register_value;
        logic [WORD_W-1:0] print_memory_value;
        logic              stack_fault;
    } result_t;
endpackage

@@ sv/tcie_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tcie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ sv/tcie_divider.sv @@
// Iterative signed divider, one quotient bit per cycle; x/0 gives 0.
// Depends on tcie_pkg.
module tcie_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [tcie_pkg::WORD_W-1:0] dividend,
    input  logic [tcie_pkg::WORD_W-1:0] divisor,
    output logic                      done,
    output logic [tcie_pkg::WORD_W-1:0] quotient
);
    import tcie_pkg::*;
    localparam int CNT_W = $clog2(WORD_W + 1);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WORD_W-1:0] q_reg, d_reg, r_reg;
    logic              neg_reg, zero_reg;
    logic [WORD_W:0]   trial;
    logic [WORD_W-1:0] rem_sh;

    assign rem_sh = {r_reg[WORD_W-2:0], q_reg[WORD_W-1]};
    assign trial  = {1'b0, rem_sh} - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(WORD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg    <= dividend[WORD_W-1] ? -dividend : dividend;
            d_reg    <= divisor[WORD_W-1] ? -divisor : divisor;
            r_reg    <= '0;
            neg_reg  <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
            zero_reg <= (divisor == '0);
        end
        else if (busy_reg)
        begin
            if (!trial[WORD_W])
            begin
                r_reg <= trial[WORD_W-1:0];
                q_reg <= {q_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= rem_sh;
                q_reg <= {q_reg[WORD_W-2:0], 1'b0};
            end
        end
    end

    assign quotient = zero_reg ? '0 : (neg_reg ? -q_reg : q_reg);
endmodule

@@ sv/toy_cpu_instruction_executor.sv @@
// Top level of the two-operand instruction executor.
// Depends on tcie_pkg, tcie_ram, tcie_divider.
//
// Channel  | Dir | Content
// s_axis   | in  | tdata = command[4:0], field_a[14:5], field_b[30:15]
// m_axis   | out | tdata = next_pc, halted, print_valid, print_register_value,
//          |     |         print_memory_value, stack_fault (78 bits, padded to 80)
// cfg      | in  | cfg_we / cfg_wdata = program_length
//
// One request at a time: accept in idle, fetch regs, read memory, execute and
// write back, then hold the result register until it is taken on m_axis.
// Divide waits in a divide state for the iterative divider.
// The register file and data memory are cleared by a sweep over the larger of
// MEM_DEPTH and REG_COUNT addresses after reset; no request is accepted during it.
// s_axis_tready is low while a request is in flight or a result waits.
module toy_cpu_instruction_executor #(
    parameter int REG_COUNT   = 16,
    parameter int MEM_DEPTH   = 1024,
    parameter int STACK_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // command, field_a, field_b, pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // next_pc, halted, print_valid, prv, pmv, fault, pad
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata       // program_length
);
    import tcie_pkg::*;

    localparam int RA_W = $clog2(REG_COUNT);
    localparam int MA_W = $clog2(MEM_DEPTH);
    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int SA_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CLR_N = (MEM_DEPTH > REG_COUNT) ? MEM_DEPTH : REG_COUNT;
    localparam int CLR_W = $clog2(CLR_N) + 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_REG   = 3'd2;
    localparam logic [2:0] ST_MEM   = 3'd3;
    localparam logic [2:0] ST_EXEC  = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]        state_reg;
    logic [CLR_W-1:0]  clr_reg;
    logic [PC_W-1:0]   pc_reg, plen_reg;
    logic [SP_W-1:0]   sp_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [FA_W-1:0]   fa_reg;
    logic [FB_W-1:0]   fb_reg;
    logic [WORD_W-1:0] va_reg, vb_reg;
    result_t           res_reg;

    // register file: two RAMs holding identical copies for two read ports
    logic              rf_we;
    logic [RA_W-1:0]   rf_waddr, rf_ra, rf_rb;
    logic [WORD_W-1:0] rf_wdata, rf_qa, rf_qb;
    // data memory
    logic              dm_we;
    logic [MA_W-1:0]   dm_waddr, dm_raddr;
    logic [WORD_W-1:0] dm_wdata, dm_q;
    // return stack
    logic [FA_W-1:0]   rs_mem [STACK_DEPTH];

    logic              div_start, div_done;
    logic [WORD_W-1:0] div_q;

    logic [CMD_W-1:0]  in_cmd;
    logic [FA_W-1:0]   in_fa;
    logic [FB_W-1:0]   in_fb;
    assign in_cmd = s_axis_tdata[4:0];
    assign in_fa  = s_axis_tdata[14:5];
    assign in_fb  = s_axis_tdata[30:15];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {2'b00, res_reg.stack_fault, res_reg.print_memory_value,
                            res_reg.print_register_value, res_reg.print_valid,
                            res_reg.halted, res_reg.next_pc};

    assign rf_ra = s_axis_tready ? in_fa[RA_W-1:0] : fa_reg[RA_W-1:0];
    assign rf_rb = s_axis_tready ? in_fb[RA_W-1:0] : fb_reg[RA_W-1:0];

    tcie_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_a (
        .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
        .raddr(rf_ra), .rdata(rf_qa));
    tcie_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_b (
        .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
        .raddr(rf_rb), .rdata(rf_qb));
    tcie_ram #(.WIDTH(WORD_W), .DEPTH(MEM_DEPTH)) u_dm (
        .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
        .raddr(dm_raddr), .rdata(dm_q));
    tcie_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(va_reg),
        .divisor(vb_reg), .done(div_done), .quotient(div_q));

    // compare helpers
    logic lt_ab, lt_ba;
    assign lt_ab = $signed(va_reg) < $signed(vb_reg);
    assign lt_ba = $signed(vb_reg) < $signed(va_reg);

    function automatic logic [WORD_W-1:0] cmpw(input logic c);
        return c ? WORD_W'(1) : '1;
    endfunction

    // memory read address: load by vb, print by fb, call by fa
    always_comb
    begin
        case (cmd_reg)
            OP_LD:   dm_raddr = vb_reg[MA_W-1:0];
            OP_PRT:  dm_raddr = MA_W'(fb_reg);
            default: dm_raddr = MA_W'(fa_reg);
        endcase
    end

    logic              wb_en;
    logic [WORD_W-1:0] wb_val;
    logic [PC_W-1:0]   nxt;
    logic              fault;
    logic              push, pop;
    logic [WORD_W-1:0] mul_res;
    assign mul_res = va_reg * vb_reg;

    always_comb
    begin
        wb_en = 1'b1;
        wb_val = '0;
        nxt = pc_reg + 1'b1;
        fault = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        case (cmd_reg)
            OP_ADD: wb_val = va_reg + vb_reg;
            OP_SUB: wb_val = va_reg - vb_reg;
            OP_MUL: wb_val = mul_res;
            OP_DIV: wb_val = div_q;
            OP_LD:  wb_val = dm_q;
            OP_IMM: wb_val = {{(WORD_W-FB_W){fb_reg[FB_W-1]}}, fb_reg};
            OP_EQU: wb_val = cmpw(va_reg == vb_reg);
            OP_LT:  wb_val = cmpw(lt_ab);
            OP_LE:  wb_val = cmpw(!lt_ba);
            OP_GT:  wb_val = cmpw(lt_ba);
            OP_GE:  wb_val = cmpw(!lt_ab);
            OP_JMPC:
            begin
                wb_en = 1'b0;
                if (vb_reg == '1)
                begin
                    nxt = PC_W'(fa_reg) + 1'b1;
                end
            end
            OP_CALL:
            begin
                wb_en = 1'b0;
                nxt = PC_W'(dm_q[FA_W-1:0]) + 1'b1;
                if (sp_reg < SP_W'(STACK_DEPTH))
                begin
                    push = 1'b1;
                end
                else
                begin
                    fault = 1'b1;
                end
            end
            OP_RET:
            begin
                wb_en = 1'b0;
                if (sp_reg != '0)
                begin
                    pop = 1'b1;
                    nxt = PC_W'(rs_mem[SA_W'(sp_reg - 1'b1)]) + 1'b1;
                end
                else
                begin
                    fault = 1'b1;
                end
            end
            OP_JMP:
            begin
                wb_en = 1'b0;
                nxt = PC_W'(fa_reg) + 1'b1;
            end
            default: wb_en = 1'b0;
        endcase
    end

    logic exec_now;
    assign exec_now = (state_reg == ST_EXEC && cmd_reg != OP_DIV)
                   || (state_reg == ST_DIV && div_done);

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            rf_we    = 1'b1;
            rf_waddr = clr_reg[RA_W-1:0];
            rf_wdata = '0;
            dm_we    = 1'b1;
            dm_waddr = clr_reg[MA_W-1:0];
            dm_wdata = '0;
        end
        else
        begin
            rf_we    = exec_now && wb_en;
            rf_waddr = fa_reg[RA_W-1:0];
            rf_wdata = wb_val;
            dm_we    = exec_now && (cmd_reg == OP_ST);
            dm_waddr = va_reg[MA_W-1:0];
            dm_wdata = vb_reg;
        end
    end

    assign div_start = (state_reg == ST_EXEC) && (cmd_reg == OP_DIV);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            pc_reg    <= '0;
            plen_reg  <= '0;
            sp_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                plen_reg <= cfg_wdata;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CLR_W'(CLR_N - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        state_reg <= ST_REG;
                    end
                end
                ST_REG:  state_reg <= ST_MEM;
                ST_MEM:  state_reg <= ST_EXEC;
                ST_EXEC: state_reg <= (cmd_reg == OP_DIV) ? ST_DIV : ST_OUT;
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (exec_now)
            begin
                pc_reg <= nxt;
                if (push)
                begin
                    sp_reg <= sp_reg + 1'b1;
                end
                else if (pop)
                begin
                    sp_reg <= sp_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            cmd_reg <= in_cmd;
            fa_reg  <= in_fa;
            fb_reg  <= in_fb;
        end
        if (state_reg == ST_REG)
        begin
            va_reg <= rf_qa;
            vb_reg <= rf_qb;
        end
        if (exec_now)
        begin
            if (push)
            begin
                rs_mem[SA_W'(sp_reg)] <= fb_reg[FA_W-1:0];
            end
            res_reg.next_pc     <= nxt;
            res_reg.halted      <= (nxt >= plen_reg);
            res_reg.print_valid <= (cmd_reg == OP_PRT);
            res_reg.print_register_value <= (cmd_reg == OP_PRT) ? va_reg : '0;
            res_reg.print_memory_value   <= (cmd_reg == OP_PRT) ? dm_q : '0;
            res_reg.stack_fault <= fault;
        end
    end

    ast_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer out of range");
    ast_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("accept while busy");
    ast_fault_no_move: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_now && fault) |=> $stable(sp_reg))
        else $error("stack moved on fault");
    ast_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(res_reg))
        else $error("result changed while stalled");
endmodule

@@ test/toy_cpu_instruction_executor_test.sv @@
// Self-checking bench for toy_cpu_instruction_executor: random and directed requests
// are checked against a behavioral machine model kept in the bench.
// Depends on tcie_pkg and the executor RTL.
`timescale 1ns / 100ps

module toy_cpu_instruction_executor_test;
    import tcie_pkg::*;

    localparam int NREG = 16;
    localparam int NMEM = 1024;
    localparam int NSTK = 8;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [FB_W-1:0]  fb;
        logic [FA_W-1:0]  fa;
        logic [CMD_W-1:0] cmd;
    } request_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic        cfg_we;
    logic [10:0] cfg_wdata;

    toy_cpu_instruction_executor dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // machine model state
    logic [31:0]     mdl_regs [NREG];
    logic [31:0]     mdl_mem [NMEM];
    logic [9:0]      mdl_stack [NSTK];
    int              mdl_sp;
    logic [PC_W-1:0] mdl_pc;
    logic [PC_W-1:0] mdl_len;

    request_t pending_requests[$];
    result_t  expected_results[$];
    int       fail_count;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       quiet_cycles;
    bit       timed_out;

    function automatic logic [31:0] cmp_word(bit c);
        return c ? 32'd1 : 32'hFFFF_FFFF;
    endfunction

    function automatic logic [31:0] sdiv(logic [31:0] x, logic [31:0] y);
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] q;
        if (y == 0)
            return 0;
        mx = x[31] ? -x : x;
        my = y[31] ? -y : y;
        q = mx / my;
        return (x[31] != y[31]) ? -q : q;
    endfunction

    // Executes one request on the model and returns the result it should give.
    function automatic result_t execute_request(request_t r);
        result_t res;
        int ra;
        int rb;
        logic signed [31:0] va;
        logic signed [31:0] vb;
        logic [PC_W-1:0] nxt;
        ra = r.fa % NREG;
        rb = r.fb % NREG;
        va = mdl_regs[ra];
        vb = mdl_regs[rb];
        nxt = mdl_pc + 1'b1;
        res = '0;
        case (r.cmd)
            OP_ADD:  mdl_regs[ra] = va + vb;
            OP_SUB:  mdl_regs[ra] = va - vb;
            OP_MUL:  mdl_regs[ra] = va * vb;
            OP_DIV:  mdl_regs[ra] = sdiv(va, vb);
            OP_ST:   mdl_mem[va[9:0]] = vb;
            OP_LD:   mdl_regs[ra] = mdl_mem[vb[9:0]];
            OP_IMM:  mdl_regs[ra] = {{16{r.fb[15]}}, r.fb};
            OP_EQU:  mdl_regs[ra] = cmp_word(va == vb);
            OP_LT:   mdl_regs[ra] = cmp_word(va < vb);
            OP_LE:   mdl_regs[ra] = cmp_word(va <= vb);
            OP_GT:   mdl_regs[ra] = cmp_word(va > vb);
            OP_GE:   mdl_regs[ra] = cmp_word(va >= vb);
            OP_JMPC: if (vb == -1) nxt = PC_W'(r.fa) + 1'b1;
            OP_CALL:
            begin
                nxt = PC_W'(mdl_mem[r.fa][9:0]) + 1'b1;
                if (mdl_sp < NSTK)
                begin
                    mdl_stack[mdl_sp] = r.fb[9:0];
                    mdl_sp++;
                end
                else
                    res.stack_fault = 1'b1;
            end
            OP_RET:
            begin
                if (mdl_sp > 0)
                begin
                    mdl_sp--;
                    nxt = PC_W'(mdl_stack[mdl_sp]) + 1'b1;
                end
                else
                    res.stack_fault = 1'b1;
            end
            OP_PRT:
            begin
                res.print_valid = 1'b1;
                res.print_register_value = va;
                res.print_memory_value = mdl_mem[r.fb[9:0]];
            end
            OP_JMP:  nxt = PC_W'(r.fa) + 1'b1;
            default: ;
        endcase
        mdl_pc = nxt;
        res.next_pc = nxt;
        res.halted = (nxt >= mdl_len);
        return res;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Driver: one request at a time from the pending queue; valid held until accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(execute_request(pending_requests.pop_front()));
            // next request is taken from the queue head once the previous one left
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {1'b0, pending_requests[0]};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Monitor: random backpressure and field-by-field comparison.
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                // tdata carries next_pc in the lowest bits, stack_fault at bit 77
                got.next_pc              = m_axis_tdata[10:0];
                got.halted               = m_axis_tdata[11];
                got.print_valid          = m_axis_tdata[12];
                got.print_register_value = m_axis_tdata[44:13];
                got.print_memory_value   = m_axis_tdata[76:45];
                got.stack_fault          = m_axis_tdata[77];
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: %h", got);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.next_pc !== want.next_pc)
                    begin
                        $error("next_pc exp %0d got %0d", want.next_pc, got.next_pc);
                        fail_count++;
                    end
                    if (got.halted !== want.halted)
                    begin
                        $error("halted exp %0d got %0d", want.halted, got.halted);
                        fail_count++;
                    end
                    if (got.print_valid !== want.print_valid)
                    begin
                        $error("print_valid exp %0d got %0d",
                               want.print_valid, got.print_valid);
                        fail_count++;
                    end
                    if (got.print_register_value !== want.print_register_value)
                    begin
                        $error("print_register_value exp %h got %h",
                               want.print_register_value, got.print_register_value);
                        fail_count++;
                    end
                    if (got.print_memory_value !== want.print_memory_value)
                    begin
                        $error("print_memory_value exp %h got %h",
                               want.print_memory_value, got.print_memory_value);
                        fail_count++;
                    end
                    if (got.stack_fault !== want.stack_fault)
                    begin
                        $error("stack_fault exp %0d got %0d",
                               want.stack_fault, got.stack_fault);
                        fail_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: counts cycles with no request or result accepted.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("simulation failed");
            $finish;
        end
    end

    function automatic request_t make_request(logic [CMD_W-1:0] c, logic [FA_W-1:0] a,
                                              logic [FB_W-1:0] b);
        request_t r;
        r.cmd = c;
        r.fa = a;
        r.fb = b;
        return r;
    endfunction

    // Random request; mostly well-formed opcodes with small register/memory spans.
    function automatic request_t random_request();
        request_t r;
        int k;
        k = $urandom_range(99);
        r.cmd = (k < 5) ? CMD_W'($urandom_range(31)) : CMD_W'($urandom_range(16));
        r.fa = ($urandom_range(3) == 0) ? FA_W'($urandom) : FA_W'($urandom_range(15));
        if (r.cmd == OP_IMM)
            r.fb = ($urandom_range(1)) ? FB_W'($urandom) : FB_W'($urandom_range(40));
        else
            r.fb = ($urandom_range(3) == 0) ? FB_W'($urandom) : FB_W'($urandom_range(15));
        // keep some calls and returns unbalanced to hit both stack limits
        if (k >= 95)
            r.cmd = (k & 1) ? OP_CALL : OP_RET;
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_length(logic [10:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        mdl_len = v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        logic [10:0] lengths [4];
        fail_count = 0;
        timed_out = 1'b0;
        quiet_cycles = 0;
        send_idle_pct = 21;
        recv_idle_pct = 76;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        mdl_sp = 0;
        mdl_pc = '0;
        mdl_len = '0;
        foreach (mdl_regs[i]) mdl_regs[i] = '0;
        foreach (mdl_mem[i]) mdl_mem[i] = '0;
        foreach (mdl_stack[i]) mdl_stack[i] = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        write_length(11'd1024);

        // directed: extremes, every opcode, divide corner cases, stack limits
        pending_requests.push_back(make_request(OP_IMM, 10'd1, 16'h8000));
        pending_requests.push_back(make_request(OP_IMM, 10'd2, 16'h7FFF));
        pending_requests.push_back(make_request(OP_MUL, 10'd1, 16'd2));
        pending_requests.push_back(make_request(OP_MUL, 10'd1, 16'd2)); // product wraps to a positive value
        pending_requests.push_back(make_request(OP_IMM, 10'd3, 16'hFFFF));
        pending_requests.push_back(make_request(OP_DIV, 10'd1, 16'd3));  // divide by minus one
        pending_requests.push_back(make_request(OP_DIV, 10'd2, 16'd0));  // divide by zero
        pending_requests.push_back(make_request(OP_ADD, 10'd4, 16'd3));
        pending_requests.push_back(make_request(OP_SUB, 10'h3FF, 16'hFFF0));
        pending_requests.push_back(make_request(OP_ST, 10'd5, 16'd3));
        pending_requests.push_back(make_request(OP_LD, 10'd6, 16'd5));
        for (int c = OP_EQU; c <= OP_GE; c++)
            pending_requests.push_back(make_request(CMD_W'(c), 10'd7, 16'd3));
        pending_requests.push_back(make_request(OP_JMPC, 10'h3FF, 16'd3));
        pending_requests.push_back(make_request(OP_RET, 10'd0, 16'd0)); // underflow
        for (int i = 0; i < 9; i++)                                     // last overflows
            pending_requests.push_back(make_request(OP_CALL, 10'h3FF, 16'hFFFF));
        pending_requests.push_back(make_request(OP_RET, 10'd0, 16'd0));
        pending_requests.push_back(make_request(OP_PRT, 10'd3, 16'hFFFF));
        pending_requests.push_back(make_request(OP_JMP, 10'h3FF, 16'd0));
        pending_requests.push_back(make_request(5'd31, 10'd0, 16'd0));
        wait_drained();

        lengths[0] = 11'd0;
        lengths[1] = 11'd37;
        lengths[2] = 11'd600;
        lengths[3] = 11'd1024;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_length(lengths[ph]);
            if (ph == 1)
            begin
                send_idle_pct = 76;
                recv_idle_pct = 21;
            end
            else if (ph >= 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int i = 0; i < 125; i++)
                pending_requests.push_back(random_request());
            wait_drained();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
